[hdl/hs1k_pkg.sv]
package hs1k_pkg;

    typedef logic [4:0][31:0]  t_state;
    typedef logic [15:0][31:0] t_blk;

    localparam int unsigned ROUNDS = 80;

    localparam t_state SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5C;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // Word 0 of the state is a, word 4 is e.
    function automatic t_state sha1_round(input t_state s, input logic [31:0] w,
                                          input int unsigned k);
        logic [31:0] f;
        logic [31:0] kc;
        logic [31:0] t;
        t_state      r;
        if (k < 20) begin
            f  = (s[1] & s[2]) | (~s[1] & s[3]);
            kc = K0;
        end else if (k < 40) begin
            f  = s[1] ^ s[2] ^ s[3];
            kc = K1;
        end else if (k < 60) begin
            f  = (s[1] & s[2]) | (s[1] & s[3]) | (s[2] & s[3]);
            kc = K2;
        end else begin
            f  = s[1] ^ s[2] ^ s[3];
            kc = K3;
        end
        t    = rotl(s[0], 5) + f + s[4] + kc + w;
        r[4] = s[3];
        r[3] = s[2];
        r[2] = rotl(s[1], 30);
        r[1] = s[0];
        r[0] = t;
        sha1_round = r;
    endfunction

    // Sliding sixteen-word window of the message schedule.
    function automatic t_blk next_window(input t_blk w);
        t_blk r;
        for (int j = 0; j < 15; j++) begin
            r[j] = w[j + 1];
        end
        r[15] = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
        next_window = r;
    endfunction

endpackage

[hdl/hmac_sha1_seed_to_key.sv]
// HMAC-SHA1 seed-to-key. Each seed word on the input channel gives one key word, the first
// OUT_BYTES bytes of HMAC-SHA1 over the seed under the key held in the register at address 0.
// The four SHA-1 compressions (inner key block, seed block, outer key block, inner digest block)
// are each a pipeline of 80 round stages plus a final add stage, so a word is taken every cycle
// unless the pipeline is held, and passes through the four compressions in order. The whole
// pipeline holds while the output word waits, and runs on as soon as it is taken.
module hmac_sha1_seed_to_key
    import hs1k_pkg::*;
#(
    parameter int SEED_BYTES = 16,
    parameter int KEY_BYTES  = 8,
    parameter int OUT_BYTES  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_seed_hi,
    input  logic [63:0] i_seed_lo,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_key_hi,
    output logic [63:0] o_key_lo,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int SLEN = (SEED_BYTES > 55) ? 55 : SEED_BYTES;
    localparam logic [31:0] SEED_BITS  = 32'((64 + SLEN) * 8);
    localparam logic [31:0] INNER_BITS = 32'((64 + 20) * 8);

    logic [63:0] r_key;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? r_key : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 64'd0;
        end else if (psel && penable && pwrite && paddr[3] == 1'b0) begin
            r_key <= pwdata;
        end
    end

    function automatic t_blk key_block(input logic [63:0] key, input logic [7:0] fill);
        t_blk b;
        for (int i = 0; i < 64; i++) begin
            if (i < KEY_BYTES && i < 8) begin
                b[i/4][31-8*(i%4) -: 8] = key[63-8*i -: 8] ^ fill;
            end else begin
                b[i/4][31-8*(i%4) -: 8] = fill;
            end
        end
        key_block = b;
    endfunction

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Stage one: inner key block.
    logic         c1_v;
    t_state       c1_h;
    logic [191:0] c1_side;

    hs1k_compress #(.SIDE_W(192)) u_c1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_h     (SHA1_IV),
        .i_blk   (key_block(r_key, IPAD_BYTE)),
        .i_side  ({i_seed_hi, i_seed_lo, r_key}),
        .o_valid (c1_v),
        .o_h     (c1_h),
        .o_side  (c1_side)
    );

    // Stage two: padded seed block.
    t_blk         seed_blk;
    logic [127:0] seed;

    assign seed = c1_side[191:64];

    always_comb begin
        seed_blk = '0;
        for (int i = 0; i < 64; i++) begin
            if (i < SLEN && i < 16) begin
                seed_blk[i/4][31-8*(i%4) -: 8] = seed[127-8*i -: 8];
            end else if (i == SLEN) begin
                seed_blk[i/4][31-8*(i%4) -: 8] = PAD_MARK;
            end
        end
        seed_blk[15] = SEED_BITS;
    end

    logic        c2_v;
    t_state      c2_h;
    logic [63:0] c2_side;

    hs1k_compress #(.SIDE_W(64)) u_c2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c1_v),
        .i_h     (c1_h),
        .i_blk   (seed_blk),
        .i_side  (c1_side[63:0]),
        .o_valid (c2_v),
        .o_h     (c2_h),
        .o_side  (c2_side)
    );

    // Stage three: outer key block, with the inner digest riding along.
    logic   c3_v;
    t_state c3_h;
    t_state c3_side;

    hs1k_compress #(.SIDE_W(160)) u_c3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c2_v),
        .i_h     (SHA1_IV),
        .i_blk   (key_block(c2_side, OPAD_BYTE)),
        .i_side  (c2_h),
        .o_valid (c3_v),
        .o_h     (c3_h),
        .o_side  (c3_side)
    );

    // Stage four: padded inner digest block.
    t_blk inner_blk;

    always_comb begin
        inner_blk = '0;
        for (int j = 0; j < 5; j++) begin
            inner_blk[j] = c3_side[j];
        end
        inner_blk[5]  = {PAD_MARK, 24'd0};
        inner_blk[15] = INNER_BITS;
    end

    t_state       c4_h;
    logic         c4_side;

    hs1k_compress #(.SIDE_W(1)) u_c4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c3_v),
        .i_h     (c3_h),
        .i_blk   (inner_blk),
        .i_side  (1'b0),
        .o_valid (o_valid),
        .o_h     (c4_h),
        .o_side  (c4_side)
    );

    logic [127:0] digest;

    always_comb begin
        digest = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < OUT_BYTES) begin
                digest[127-8*i -: 8] = c4_h[i/4][31-8*(i%4) -: 8];
            end
        end
        digest[0] = digest[0] | (c4_side & 1'b0);
    end

    assign o_key_hi = digest[127:64];
    assign o_key_lo = digest[63:0];

endmodule

[hdl/hs1k_compress.sv]
module hs1k_compress
    import hs1k_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_state            i_h,
    input  t_blk              i_blk,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_state            o_h,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [ROUNDS];
    t_state            r_st   [ROUNDS];
    t_blk              r_w    [ROUNDS];
    t_state            r_h    [ROUNDS];
    logic [SIDE_W-1:0] r_side [ROUNDS];

    logic              r_ov;
    t_state            r_oh;
    logic [SIDE_W-1:0] r_oside;

    // One round per stage; the chaining value and side data ride along.
    for (genvar k = 0; k < ROUNDS; k++) begin : g_rnd
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k]   <= sha1_round(i_h, i_blk[0], k);
                    r_w[k]    <= next_window(i_blk);
                    r_h[k]    <= i_h;
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k]   <= sha1_round(r_st[k-1], r_w[k-1][0], k);
                    r_w[k]    <= next_window(r_w[k-1]);
                    r_h[k]    <= r_h[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[ROUNDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 5; j++) begin
                r_oh[j] <= r_h[ROUNDS-1][j] + r_st[ROUNDS-1][j];
            end
            r_oside <= r_side[ROUNDS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_h     = r_oh;
    assign o_side  = r_oside;

endmodule
